// File: hdl/contiguous_page_allocator_unit_defines.svh
// Assertion macros shared by the contiguous page allocator modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define CPA_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the same cycle.
`define CPA_ASSERT_IMPLY(lbl, clk, rst, trig, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`endif

// File: hdl/cpa_pkg.sv
// Shared types and constants of the contiguous page allocator.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
package cpa_pkg;

   localparam int MAX_PROCESSES = 64;
   localparam int SLOT_W        = $clog2(MAX_PROCESSES);
   localparam int SCAN_W        = SLOT_W + 1;
   localparam int MAX_PAGES     = 4096;
   localparam int PAGE_W        = 12;
   localparam int LEN_W         = 13;
   localparam int ID_W          = 16;
   localparam int CNT_W         = 16;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_RESERVE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_READ    = 2'd2,
      OP_WRITE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOSPACE = 3'd1,
      ST_UNKNOWN = 3'd2,
      ST_FULL    = 3'd3,
      ST_RANGE   = 3'd4
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   owner;
      logic [PAGE_W-1:0] first_page;
      logic [LEN_W-1:0]  length;
      logic [CNT_W-1:0]  reads;
      logic [CNT_W-1:0]  writes;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_SCAN,
      S_DECIDE,
      S_COMPACT,
      S_COMPACT_END
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       scan_start;
      logic       gap_step;
      logic       gap_final;
      logic       compact_begin;
      logic       compact_step;
      logic       alloc;
      logic       exec_op;
      logic       fail;
      status_type fail_status;
   } cmd_type;

   typedef struct packed {
      logic scan_busy;
      logic sel_hit;
      logic free_found;
      logic nospace;
      logic found;
      logic fit;
      logic rsp_free;
   } stat_type;

endpackage

// File: hdl/cpa_req_if.sv
// Request channel interface of the page allocator.
// Depends on cpa_pkg for field widths.
`timescale 1ns / 1ps
interface cpa_req_if import cpa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       operation;
   logic [ID_W-1:0]  process_id;
   logic [LEN_W-1:0] amount;
   modport source (output valid, operation, process_id, amount, input ready);
   modport sink (input valid, operation, process_id, amount, output ready);
endinterface

// File: hdl/cpa_rsp_if.sv
// Response channel interface of the page allocator.
// Depends on cpa_pkg for field widths.
`timescale 1ns / 1ps
interface cpa_rsp_if import cpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [2:0]        status;
   logic [PAGE_W-1:0] physical_page;
   logic              compacted;
   logic [CNT_W-1:0]  read_count;
   logic [CNT_W-1:0]  write_count;
   modport source (output valid, status, physical_page, compacted, read_count,
                   write_count, input ready);
   modport sink (input valid, status, physical_page, compacted, read_count,
                 write_count, output ready);
endinterface

// File: hdl/cpa_ctrl.sv
// Sequencing state machine of the page allocator.
// Depends on cpa_pkg; drives the datapath through cmd_type.
`timescale 1ns / 1ps
module cpa_ctrl import cpa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  op_type   req_op,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.fail_status = ST_OK;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = (req_op == OP_RESERVE) ? S_SCAN : S_FIND;
            end
         end
         S_FIND: begin
            if (!stat.scan_busy && stat.rsp_free) begin
               if (stat.sel_hit) begin
                  cmd.exec_op = 1'b1;
               end else begin
                  cmd.fail = 1'b1;
                  cmd.fail_status = ST_UNKNOWN;
               end
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (!stat.scan_busy) begin
               if (stat.sel_hit) begin
                  cmd.gap_step   = 1'b1;
                  cmd.scan_start = 1'b1;
               end else begin
                  cmd.gap_final = 1'b1;
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (stat.rsp_free) begin
               if (stat.nospace) begin
                  cmd.fail = 1'b1;
                  cmd.fail_status = ST_NOSPACE;
                  state_in = S_IDLE;
               end else if (!stat.free_found) begin
                  cmd.fail = 1'b1;
                  cmd.fail_status = ST_FULL;
                  state_in = S_IDLE;
               end else if (stat.found) begin
                  cmd.alloc = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.compact_begin = 1'b1;
                  cmd.scan_start    = 1'b1;
                  state_in = S_COMPACT;
               end
            end
         end
         S_COMPACT: begin
            if (!stat.scan_busy) begin
               if (stat.sel_hit) begin
                  cmd.compact_step = 1'b1;
                  cmd.scan_start   = 1'b1;
               end else begin
                  state_in = S_COMPACT_END;
               end
            end
         end
         S_COMPACT_END: begin
            if (stat.rsp_free) begin
               if (stat.fit) begin
                  cmd.alloc = 1'b1;
               end else begin
                  cmd.fail = 1'b1;
                  cmd.fail_status = ST_NOSPACE;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/cpa_datapath.sv
// Slot table, sweep unit, gap and compaction arithmetic and result register.
// Depends on cpa_pkg and the assertion macros; driven by cpa_ctrl.
`timescale 1ns / 1ps
`include "contiguous_page_allocator_unit_defines.svh"
module cpa_datapath import cpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              csr_we,
   input  logic [LEN_W-1:0]  csr_wdata,
   input  op_type            req_op,
   input  logic [ID_W-1:0]   req_id,
   input  logic [LEN_W-1:0]  req_amt,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output status_type        rsp_status,
   output logic [PAGE_W-1:0] rsp_page,
   output logic              rsp_comp,
   output logic [CNT_W-1:0]  rsp_reads,
   output logic [CNT_W-1:0]  rsp_writes
);

   localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(MAX_PROCESSES);
   localparam logic [LEN_W-1:0]  PAGES_MAX = LEN_W'(MAX_PAGES);

   entry_type mem [MAX_PROCESSES];
   entry_type q_ff;

   logic [LEN_W-1:0]  total_ff;
   op_type            op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [LEN_W-1:0]  amt_ff;
   logic [SCAN_W-1:0] addr_ff;
   logic              rd_vld_ff;
   logic [SLOT_W-1:0] rd_idx_ff;
   logic              find_mode_ff;
   logic [MAX_PROCESSES-1:0] valid_ff, done_ff;
   logic              sel_hit_ff;
   logic [SLOT_W-1:0] sel_idx_ff;
   entry_type         sel_ff;
   logic              free_found_ff;
   logic [SLOT_W-1:0] free_idx_ff;
   logic [LEN_W-1:0]  cur_ff, sum_ff;
   logic              found_ff, comp_ff;
   logic [PAGE_W-1:0] pick_ff;

   logic [LEN_W-1:0]  tot, lim, gap, ext_end;
   logic [PAGE_W-1:0] pick_eff;
   logic              rsp_load, rsp_free, capture, in_range;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_wa;
   entry_type         mem_wd, upd;
   status_type        out_status;
   logic [PAGE_W-1:0] out_page;
   logic [CNT_W-1:0]  out_reads, out_writes;

   assign tot      = (total_ff > PAGES_MAX) ? PAGES_MAX : total_ff;
   assign lim      = (cmd.gap_step && ({1'b0, sel_ff.first_page} < tot)) ?
                     {1'b0, sel_ff.first_page} : tot;
   assign gap      = lim - cur_ff;
   assign ext_end  = {1'b0, sel_ff.first_page} + sel_ff.length;
   assign pick_eff = comp_ff ? cur_ff[PAGE_W-1:0] : pick_ff;
   assign in_range = amt_ff < sel_ff.length;
   assign rsp_free = !rsp_valid || rsp_ready;
   assign rsp_load = cmd.fail || cmd.alloc || cmd.exec_op;

   // A sweep word is taken when it matches the owner (lookup) or is the
   // lowest unvisited extent so far (ordered pass; ties keep the lower slot).
   always_comb begin
      capture = 1'b0;
      if (rd_vld_ff && valid_ff[rd_idx_ff]) begin
         if (find_mode_ff) begin
            capture = !sel_hit_ff && (q_ff.owner == id_ff);
         end else begin
            capture = !done_ff[rd_idx_ff] &&
                      (!sel_hit_ff || (q_ff.first_page < sel_ff.first_page));
         end
      end
   end

   always_comb begin
      stat.scan_busy  = (addr_ff != SCAN_END) || rd_vld_ff;
      stat.sel_hit    = sel_hit_ff;
      stat.free_found = free_found_ff;
      stat.nospace    = (amt_ff == '0) || (sum_ff < amt_ff);
      stat.found      = found_ff;
      stat.fit        = !((cur_ff > tot) || ((tot - cur_ff) < amt_ff));
      stat.rsp_free   = rsp_free;
   end

   always_comb begin
      upd = sel_ff;
      if (op_ff == OP_READ) begin
         if (sel_ff.reads != COUNT_MAX) upd.reads = sel_ff.reads + 1'b1;
      end else begin
         if (sel_ff.writes != COUNT_MAX) upd.writes = sel_ff.writes + 1'b1;
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = sel_idx_ff;
      mem_wd = upd;
      if (cmd.compact_step) begin
         mem_we = 1'b1;
         mem_wd = sel_ff;
         mem_wd.first_page = cur_ff[PAGE_W-1:0];
      end else if (cmd.alloc) begin
         mem_we = 1'b1;
         mem_wa = free_idx_ff;
         mem_wd = '{owner: id_ff, first_page: pick_eff, length: amt_ff,
                    reads: '0, writes: '0};
      end else if (cmd.exec_op && op_ff != OP_RELEASE && in_range) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      out_status = ST_OK;
      out_page   = '0;
      out_reads  = '0;
      out_writes = '0;
      if (cmd.fail) begin
         out_status = cmd.fail_status;
      end else if (cmd.alloc) begin
         out_page = pick_eff;
      end else if (op_ff == OP_RELEASE) begin
         out_reads  = sel_ff.reads;
         out_writes = sel_ff.writes;
      end else if (!in_range) begin
         out_status = ST_RANGE;
      end else begin
         out_page   = sel_ff.first_page + amt_ff[PAGE_W-1:0];
         out_reads  = upd.reads;
         out_writes = upd.writes;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (addr_ff != SCAN_END) q_ff <= mem[addr_ff[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= PAGES_MAX;
         addr_ff   <= SCAN_END;
         rd_vld_ff <= 1'b0;
         valid_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_we) total_ff <= csr_wdata;
         rd_vld_ff <= (addr_ff != SCAN_END);
         if (cmd.load_req || cmd.scan_start) begin
            addr_ff <= '0;
         end else if (addr_ff != SCAN_END) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (cmd.alloc) valid_ff[free_idx_ff] <= 1'b1;
         if (cmd.exec_op && op_ff == OP_RELEASE) valid_ff[sel_idx_ff] <= 1'b0;
         if (rsp_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff[SLOT_W-1:0];
      if (cmd.load_req) begin
         op_ff         <= req_op;
         id_ff         <= req_id;
         amt_ff        <= req_amt;
         find_mode_ff  <= (req_op != OP_RESERVE);
         free_found_ff <= 1'b0;
         cur_ff        <= '0;
         sum_ff        <= '0;
         found_ff      <= 1'b0;
         pick_ff       <= '0;
         comp_ff       <= 1'b0;
      end
      if (cmd.load_req || cmd.compact_begin) done_ff <= '0;
      if (cmd.load_req || cmd.scan_start) begin
         sel_hit_ff <= 1'b0;
      end else if (capture) begin
         sel_hit_ff <= 1'b1;
         sel_idx_ff <= rd_idx_ff;
         sel_ff     <= q_ff;
      end
      if (rd_vld_ff && !find_mode_ff && !valid_ff[rd_idx_ff] && !free_found_ff) begin
         free_found_ff <= 1'b1;
         free_idx_ff   <= rd_idx_ff;
      end
      if (cmd.gap_step || cmd.gap_final) begin
         if (lim > cur_ff) begin
            sum_ff <= sum_ff + gap;
            if (!found_ff && gap >= amt_ff) begin
               found_ff <= 1'b1;
               pick_ff  <= cur_ff[PAGE_W-1:0];
            end
         end
         if (cmd.gap_step && ext_end > cur_ff) cur_ff <= ext_end;
      end
      if (cmd.gap_step || cmd.compact_step) done_ff[sel_idx_ff] <= 1'b1;
      if (cmd.compact_begin) begin
         cur_ff  <= '0;
         comp_ff <= 1'b1;
      end
      if (cmd.compact_step) cur_ff <= cur_ff + sel_ff.length;
      if (rsp_load) begin
         rsp_status <= out_status;
         rsp_page   <= out_page;
         rsp_comp   <= comp_ff;
         rsp_reads  <= out_reads;
         rsp_writes <= out_writes;
      end
   end

   `CPA_ASSERT_IMPLY(a_alloc_free, clock, reset, cmd.alloc, free_found_ff, "alloc without free slot")
   `CPA_ASSERT_IMPLY(a_exec_hit, clock, reset, cmd.exec_op, sel_hit_ff && op_ff != OP_RESERVE, "exec without lookup hit")
   `CPA_ASSERT_IMPLY(a_load_free, clock, reset, rsp_load, rsp_free, "result overwritten")
   `CPA_ASSERT_ALWAYS(a_one_write, clock, reset, !(cmd.alloc && cmd.compact_step), "two table writes")

endmodule

// File: hdl/contiguous_page_allocator_unit.sv
// Top level of the contiguous page allocator: controller plus datapath.
// Depends on cpa_pkg, cpa_req_if, cpa_rsp_if, cpa_ctrl and cpa_datapath.
//
// Requests arrive as words on req_ch (operation, process_id, amount) and
// each produces exactly one response word on rsp_ch. The block works on
// one request at a time; a word is taken at a clock edge with valid and
// ready both high. Every lookup or ordering step is one sweep of the
// 64-entry slot table through its single read port. Release, read and write
// take one sweep, and the next request word can be taken once the response
// word has been loaded. A reserve takes (n + 1) sweeps over the n live
// extents to walk the gaps in address order, then decides in a separate
// state; when compaction runs, another (n + 1) sweeps and a closing state
// pack the extents, one extent moved per sweep.
// The response sits in an output register; a new request is accepted as
// soon as the previous one has been turned into a response word, even if
// the receiver has not yet taken it. If the receiver stalls, the block
// finishes the next request and then waits before loading its response.
// Synchronous reset clears all slot valid bits, so the table starts empty,
// and sets total_pages to 4096. The csr port writes total_pages and must
// only be used while the block is idle.
`timescale 1ns / 1ps
module contiguous_page_allocator_unit import cpa_pkg::*; (
   input logic             clock,
   input logic             reset,
   cpa_req_if.sink         req_ch,
   cpa_rsp_if.source       rsp_ch,
   input logic             csr_we,
   input logic [LEN_W-1:0] csr_wdata
);

   cmd_type    cmd;
   stat_type   stat;
   status_type rsp_status;

   // The controller sees the operation only to pick the lookup or the
   // reserve path; the datapath latches the whole word.
   cpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (op_type'(req_ch.operation)),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cpa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_op     (op_type'(req_ch.operation)),
      .req_id     (req_ch.process_id),
      .req_amt    (req_ch.amount),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_status (rsp_status),
      .rsp_page   (rsp_ch.physical_page),
      .rsp_comp   (rsp_ch.compacted),
      .rsp_reads  (rsp_ch.read_count),
      .rsp_writes (rsp_ch.write_count)
   );

   assign rsp_ch.status = rsp_status;

endmodule

// File: sim/tb_contiguous_page_allocator_unit.sv
// Self-checking testbench for contiguous_page_allocator_unit.
// Depends on cpa_pkg, cpa_req_if, cpa_rsp_if and the allocator RTL.
`timescale 1ns / 1ps
module tb_contiguous_page_allocator_unit;
   import cpa_pkg::*;

   // One expected response word.
   typedef struct {
      status_type        status;
      logic [PAGE_W-1:0] page;
      logic              compacted;
      logic [CNT_W-1:0]  reads;
      logic [CNT_W-1:0]  writes;
   } alloc_word_type;

   // Shadow of the slot table plus the queue of responses it predicts.
   class alloc_scoreboard;
      bit             live[MAX_PROCESSES];
      int             owner[MAX_PROCESSES];
      int             first[MAX_PROCESSES];
      int             len[MAX_PROCESSES];
      int             rd[MAX_PROCESSES];
      int             wr[MAX_PROCESSES];
      int             order[MAX_PROCESSES];
      int             total_pages = 4096;
      int             errors = 0;
      alloc_word_type pending_words[$];

      function int usable_pages();
         return (total_pages > MAX_PAGES) ? MAX_PAGES : total_pages;
      endfunction

      // Orders the live slots by first page, ties by slot index.
      function int sort_extents();
         int n, j;
         n = 0;
         for (int i = 0; i < MAX_PROCESSES; i++) begin
            if (live[i]) begin
               j = n;
               while (j > 0 && first[order[j-1]] > first[i]) begin
                  order[j] = order[j-1];
                  j--;
               end
               order[j] = i;
               n++;
            end
         end
         return n;
      endfunction

      // Returns the free page count below the total and the lowest fitting gap.
      function int walk_gaps(int need, output int pick, output bit found);
         int n, tot, cur, sum, lim, stop;
         n = sort_extents();
         tot = usable_pages();
         cur = 0;
         sum = 0;
         pick = 0;
         found = 0;
         for (int k = 0; k <= n; k++) begin
            lim = (k < n) ? first[order[k]] : tot;
            if (lim > tot) lim = tot;
            if (lim > cur) begin
               sum += lim - cur;
               if (!found && lim - cur >= need) begin
                  found = 1;
                  pick = cur;
               end
            end
            if (k < n) begin
               stop = first[order[k]] + len[order[k]];
               if (stop > cur) cur = stop;
            end
         end
         return sum;
      endfunction

      function int pack_extents();
         int n, cur;
         n = sort_extents();
         cur = 0;
         for (int k = 0; k < n; k++) begin
            first[order[k]] = cur;
            cur += len[order[k]];
         end
         return cur;
      endfunction

      function int lookup(int id);
         for (int i = 0; i < MAX_PROCESSES; i++)
            if (live[i] && owner[i] == id) return i;
         return -1;
      endfunction

      function int live_count();
         int n;
         n = 0;
         foreach (live[i]) n += live[i];
         return n;
      endfunction

      // Works out the response to an accepted request word and updates the table.
      function void note_request(op_type op, int id, int amt);
         alloc_word_type w;
         int             s, pick, freesum, free_slot;
         bit             found;
         w = '{ST_OK, '0, 1'b0, '0, '0};
         if (op == OP_RESERVE) begin
            freesum = walk_gaps(amt, pick, found);
            free_slot = -1;
            for (int i = MAX_PROCESSES - 1; i >= 0; i--)
               if (!live[i]) free_slot = i;
            if (amt == 0 || freesum < amt) begin
               w.status = ST_NOSPACE;
            end else if (free_slot < 0) begin
               w.status = ST_FULL;
            end else begin
               if (!found) begin
                  pick = pack_extents();
                  w.compacted = 1'b1;
                  if (pick > usable_pages() || usable_pages() - pick < amt)
                     w.status = ST_NOSPACE;
               end
               if (w.status == ST_OK) begin
                  live[free_slot] = 1;
                  owner[free_slot] = id;
                  first[free_slot] = pick;
                  len[free_slot] = amt;
                  rd[free_slot] = 0;
                  wr[free_slot] = 0;
                  w.page = PAGE_W'(pick);
               end
            end
         end else begin
            s = lookup(id);
            if (s < 0) begin
               w.status = ST_UNKNOWN;
            end else if (op == OP_RELEASE) begin
               live[s] = 0;
               w.reads = CNT_W'(rd[s]);
               w.writes = CNT_W'(wr[s]);
            end else if (amt >= len[s]) begin
               w.status = ST_RANGE;
            end else begin
               w.page = PAGE_W'(first[s] + amt);
               if (op == OP_READ) begin
                  if (rd[s] < COUNT_MAX) rd[s]++;
               end else begin
                  if (wr[s] < COUNT_MAX) wr[s]++;
               end
               w.reads = CNT_W'(rd[s]);
               w.writes = CNT_W'(wr[s]);
            end
         end
         pending_words.push_back(w);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(alloc_word_type got);
         alloc_word_type w;
         if (pending_words.size() == 0) begin
            report("response word with none expected");
            return;
         end
         w = pending_words.pop_front();
         if (got.status != w.status)
            report($sformatf("status %0d, expected %0d", got.status, w.status));
         if (got.page != w.page)
            report($sformatf("physical_page %0d, expected %0d", got.page, w.page));
         if (got.compacted != w.compacted)
            report($sformatf("compacted %0d, expected %0d", got.compacted, w.compacted));
         if (got.reads != w.reads)
            report($sformatf("read_count %0d, expected %0d", got.reads, w.reads));
         if (got.writes != w.writes)
            report($sformatf("write_count %0d, expected %0d", got.writes, w.writes));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [LEN_W-1:0] csr_wdata = '0;
   bit               stall_mode = 1'b0;
   bit               gap_mode = 1'b0;
   int               stall_left = 0;
   alloc_scoreboard  sb = new();

   cpa_req_if req_ch ();
   cpa_rsp_if rsp_ch ();

   contiguous_page_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = '0;
      req_ch.process_id = '0;
      req_ch.amount = '0;
      rsp_ch.ready = 1'b0;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pause_length();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 150);
   endfunction

   // The response side takes words and stalls at random while stall_mode is set.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response('{status_type'(rsp_ch.status), rsp_ch.physical_page,
                             rsp_ch.compacted, rsp_ch.read_count, rsp_ch.write_count});
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (stall_mode && $urandom_range(0, 3) == 0) stall_left = pause_length();
      end
   end

   // Presents one request word and returns at the edge where it is taken.
   // The valid line stays high into the next call when no pause is drawn.
   task automatic send_request(op_type op, int id, int amt);
      if (gap_mode && $urandom_range(0, 9) < 6) begin
         req_ch.valid <= 1'b0;
         repeat (pause_length()) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.process_id <= id[ID_W-1:0];
      req_ch.amount <= amt[LEN_W-1:0];
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_request(op, id & 16'hFFFF, amt & 13'h1FFF);
   endtask

   // Waits until every response is in, then writes total_pages.
   task automatic write_total(int value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value[LEN_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.total_pages = value & 13'h1FFF;
   endtask

   // Picks the owner of a random live slot, or a random id if none is live.
   function automatic int live_owner();
      int ids[$];
      foreach (sb.live[i]) if (sb.live[i]) ids.push_back(sb.owner[i]);
      if (ids.size() == 0) return $urandom_range(0, 65535);
      return ids[$urandom_range(0, ids.size() - 1)];
   endfunction

   // Random traffic: reserves sized to the current total, accesses to live
   // processes mostly in range, and a little noise with unknown ids.
   task automatic random_phase(int count);
      int pick, id, slot, amt, lim;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         lim = sb.usable_pages();
         if (sb.live_count() > 10 && pick < 30) pick = 30;
         if (pick < 30) begin
            case ($urandom_range(0, 9))
               0:       amt = $urandom_range(0, 8191);
               1, 2:    amt = $urandom_range(0, (lim > 0) ? lim : 1);
               default: amt = $urandom_range(1, (lim > 8) ? lim / 8 : 1);
            endcase
            id = ($urandom_range(0, 9) == 0) ? live_owner() : $urandom_range(0, 65535);
            send_request(OP_RESERVE, id, amt);
         end else if (pick < 48) begin
            send_request(OP_RELEASE, live_owner(), $urandom_range(0, 8191));
         end else if (pick < 92) begin
            id = live_owner();
            slot = sb.lookup(id);
            if (slot >= 0 && $urandom_range(0, 9) < 8)
               amt = $urandom_range(0, sb.len[slot] - 1);
            else
               amt = $urandom_range(0, 8191);
            send_request($urandom_range(0, 1) ? OP_READ : OP_WRITE, id, amt);
         end else begin
            send_request(op_type'($urandom_range(1, 3)), $urandom_range(0, 65535),
                         $urandom_range(0, 8191));
         end
      end
   endtask

   initial begin
      int totals[7];
      totals = '{8191, 300, 64, 4096, 1, 0, 2500};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero-page reserve, a reserve of the full table extent, a reserve that finds
      // no room, and accesses at both ends of the extent; amount 4096 is past the last page.
      send_request(OP_RESERVE, 0, 0);
      send_request(OP_RESERVE, 16'hFFFF, 4096);
      send_request(OP_RESERVE, 1, 1);
      send_request(OP_READ, 16'hFFFF, 4095);
      send_request(OP_WRITE, 16'hFFFF, 0);
      send_request(OP_READ, 16'hFFFF, 4096);
      send_request(OP_WRITE, 16'hFFFF, 8191);
      send_request(OP_RELEASE, 16'hFFFF, 0);
      send_request(OP_READ, 16'h1234, 0);
      send_request(OP_RELEASE, 16'h1234, 0);
      send_request(OP_RESERVE, 5, 10);
      send_request(OP_RESERVE, 6, 20);
      send_request(OP_RESERVE, 7, 30);
      send_request(OP_RESERVE, 7, 5);
      send_request(OP_RELEASE, 6, 0);
      send_request(OP_WRITE, 7, 2);

      // With a 100-page total the 30-page reserve fits in the gap above the last
      // extent. A later shrink leaves extents past the total; a 15-page reserve
      // still fits in the gap below them and an 8191-page one finds no room.
      write_total(100);
      send_request(OP_RESERVE, 9, 30);
      send_request(OP_READ, 9, 29);
      send_request(OP_RELEASE, 5, 0);
      write_total(60);
      send_request(OP_RESERVE, 10, 15);
      send_request(OP_RESERVE, 10, 8191);

      // Fill every slot, then check that no space wins over table full.
      write_total(4096);
      gap_mode = 1'b1;
      stall_mode = 1'b1;
      while (sb.live_count() < MAX_PROCESSES)
         send_request(OP_RESERVE, $urandom_range(0, 65535), 1);
      send_request(OP_RESERVE, 42, 2);
      send_request(OP_RESERVE, 42, 4096);
      while (sb.live_count() > 0) send_request(OP_RELEASE, live_owner(), 0);

      foreach (totals[p]) begin
         write_total(totals[p]);
         gap_mode = (p % 3) != 0;
         stall_mode = (p % 2) != 0;
         random_phase(50);
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Time limit well above the slowest correct run.
   initial begin
      #300000000;
      $display("status: fail");
      $finish;
   end
endmodule
